@@ src/mavg_pkg.sv @@
// Shared constants and command struct for the moving average filter.
// No dependencies; imported by every module of the block.
package mavg_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SMP_W      = 16;
  localparam int SUM_W      = SMP_W + ADDR_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture sample, read old slot
    logic update;    // fold sample into sum, write slot
    logic prep;      // load divider
    logic div_step;  // one quotient bit
    logic load_out;  // saturate quotient into output register
  } mavg_cmd_t;

endpackage

@@ src/mavg_ctrl.sv @@
// Sequencer for the moving average filter: handshakes and divider step count.
// Depends on mavg_pkg.
module mavg_ctrl import mavg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output mavg_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/mavg_dp.sv @@
// Datapath: window memory, running sum, fill count, restoring divider, output.
// Depends on mavg_pkg.
module mavg_dp import mavg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mavg_cmd_t               cmd,
  input  logic                    cfg_wr,
  input  logic [LEN_W-1:0]        cfg_len,
  output logic [LEN_W-1:0]        len,
  input  logic signed [SMP_W-1:0] sample,
  output logic signed [SMP_W-1:0] average
);

  localparam logic [SUM_W-1:0] Q_POS_LIM = SUM_W'((1 << (SMP_W - 1)) - 1);
  localparam logic [SUM_W-1:0] Q_NEG_LIM = SUM_W'(1 << (SMP_W - 1));

  logic signed [SMP_W-1:0] mem [MAX_WINDOW];

  logic [LEN_W-1:0]        len_r, len_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;
  logic [LEN_W-1:0]        fill_r, fill_nxt;
  logic signed [SMP_W-1:0] smp_r;
  logic signed [SMP_W-1:0] rd_data_r;
  logic                    live_r;
  logic [SUM_W-1:0]        q_r, q_nxt;
  logic [LEN_W-1:0]        rem_r, rem_nxt;
  logic [LEN_W-1:0]        div_r;
  logic                    neg_r;
  logic signed [SMP_W-1:0] avg_r, avg_nxt;

  logic signed [SMP_W-1:0] old_smp;
  logic [LEN_W-1:0]        pos_inc;
  logic [SUM_W-1:0]        mag;
  logic [LEN_W:0]          trial;
  logic [LEN_W:0]          diff;
  logic [LEN_W-1:0]        clamp_len;

  assign len     = len_r;
  assign average = avg_r;

  // slot not yet written since the last clear reads as zero
  assign old_smp = live_r ? rd_data_r : '0;
  assign pos_inc = {1'b0, pos_r} + 1'b1;
  assign mag     = (sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r))
                   + SUM_W'(fill_r >> 1);
  assign trial   = {rem_r, q_r[SUM_W-1]};
  assign diff    = trial - {1'b0, div_r};

  always_comb begin
    clamp_len = cfg_len;
    if (cfg_len == '0) begin
      clamp_len = LEN_W'(1);
    end else if (cfg_len > LEN_MAX) begin
      clamp_len = LEN_MAX;
    end
  end

  always_comb begin
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    avg_nxt  = avg_r;
    if (cfg_wr) begin
      len_nxt  = clamp_len;
      sum_nxt  = '0;
      pos_nxt  = '0;
      fill_nxt = '0;
    end else if (cmd.update) begin
      sum_nxt  = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
      pos_nxt  = (pos_inc == len_r) ? '0 : pos_inc[ADDR_W-1:0];
      fill_nxt = (fill_r < len_r) ? fill_r + 1'b1 : fill_r;
    end
    if (cmd.prep) begin
      q_nxt   = mag;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      q_nxt = {q_r[SUM_W-2:0], ~diff[LEN_W]};
      rem_nxt = diff[LEN_W] ? trial[LEN_W-1:0] : diff[LEN_W-1:0];
    end
    if (cmd.load_out) begin
      if (neg_r) begin
        avg_nxt = (q_r > Q_NEG_LIM) ? signed'(Q_NEG_LIM[SMP_W-1:0])
                                    : signed'(SMP_W'(-q_r));
      end else begin
        avg_nxt = (q_r > Q_POS_LIM) ? signed'(Q_POS_LIM[SMP_W-1:0])
                                    : signed'(q_r[SMP_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= mem[pos_r];
    end
    if (cmd.update) begin
      mem[pos_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r  <= sample;
      live_r <= (fill_r == len_r);
    end
    if (cmd.prep) begin
      div_r <= fill_r;
      neg_r <= sum_r[SUM_W-1];
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    avg_r <= avg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_RESET;
      sum_r  <= '0;
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ src/moving_average_filter.sv @@
// Top level of the moving average filter: APB register, controller, datapath.
// Depends on mavg_pkg, mavg_ctrl and mavg_dp.
//
// Streaming moving average over signed Q15 samples. Every request on the
// input channel yields exactly one Q15 average: the running sum of the last
// window_length samples divided by the count of samples in it (those seen
// since the last clear, at most window_length, so the first outputs are
// meaningful during fill-in), rounded to nearest with ties away from zero
// for both signs, and saturated to Q15. The old slot is read from the
// window RAM at the accepting edge. After that the sequencer updates the
// running sum and writes the slot, loads the divider, runs the bit-serial
// restoring divider (one quotient bit per cycle over the 26-bit sum) and
// then saturates the quotient into the output register.
// The next request is taken in the cycle after the result is registered,
// even if the receiver is still stalling it, so a new request is accepted
// only once the previous one is through. A previous result that is still
// stalled when the next one is ready holds the sequencer in its last step
// until the receiver takes it.
// window_length sits at byte address 0; a write takes the low 11 bits of
// pwdata, clamps 0 to 1 and anything above 1024 to 1024, and clears the
// window, sum and fill count instantly (a fill counter masks stale RAM
// contents, so there is no clearing pass). Write it only while idle.
module moving_average_filter import mavg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_sample_in,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] out_average_out,
  // APB register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  mavg_cmd_t        cmd;
  logic             cfg_wr;
  logic             reg_sel;
  logic [LEN_W-1:0] len;

  // only word 0 is decoded; writes elsewhere are dropped
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? DATA_W'(len) : '0;

  mavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mavg_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .cfg_wr  (cfg_wr),
    .cfg_len (pwdata[LEN_W-1:0]),
    .len     (len),
    .sample  (in_sample_in),
    .average (out_average_out)
  );

endmodule

@@ src/mavg_checker.sv @@
// Port-level checks for the moving average filter, bound to the top level.
// Depends on mavg_pkg and moving_average_filter.
module mavg_checker import mavg_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SMP_W-1:0] out_average_out
);

  // one request in flight: stall goes up straight after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

  // a result only appears at the end of a request's processing
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without request in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_average_out)))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_average_out (out_average_out)
);

@@ sim/moving_average_filter_tb.sv @@
// Self-checking testbench for moving_average_filter: directed plan, then random phases.
// Depends on mavg_pkg and the RTL; a built-in running-sum predictor checks every untyped average.
module moving_average_filter_tb;
  import mavg_pkg::*;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int unsigned {MIX_UNIFORM, MIX_EXTREME, MIX_TIES, MIX_RAILS} sample_mix_t;

  // One line of the directed plan: a sample request or a register write.
  // want is only used when typed is set; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t                 kind;
    logic [PADDR_W-1:0]        addr;
    logic [DATA_W-1:0]         data;
    logic                      typed;
    logic signed [SMP_W-1:0]   want;
  } plan_row_t;

  localparam int PLAN_ROWS      = 26;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int IDLE_PCT       = 21;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;
  localparam int BIG_RUN        = 1030; // just over a full 1024 window, so it wraps

  localparam logic [PADDR_W-1:0] ADDR_LENGTH   = PADDR_W'({REG_WINDOW_LENGTH, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4); // register index 1: no register

  localparam logic signed [SMP_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] Q15_MIN = 16'sh8000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample_in;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_average_out;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  moving_average_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_average_out(out_average_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the window, running sum, write pointer and fill
  // count, plus the effective (clamped) window length.
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] window_slots [MAX_WINDOW];
  logic signed [SUM_W-1:0] window_total;
  int unsigned             slot_ptr;
  int unsigned             seen_count;
  int unsigned             avg_length;

  logic signed [SMP_W-1:0] avg_due [$];   // averages still owed by the block

  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_len_writes;
  int unsigned n_errors;
  logic        idle_on;

  function automatic void clear_window_state();
    foreach (window_slots[i]) window_slots[i] = '0;
    window_total = '0;
    slot_ptr     = 0;
    seen_count   = 0;
  endfunction

  // Only register index 0 exists; any write to it clears, even the same value.
  function automatic void note_length_write(logic [PADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int unsigned v;
    if (a[PADDR_W-1:2] != (PADDR_W-2)'(REG_WINDOW_LENGTH)) return;
    v = 32'(d[LEN_W-1:0]);
    if (v == 0) v = 1;
    if (v > MAX_WINDOW) v = MAX_WINDOW;
    avg_length = v;
    clear_window_state();
  endfunction

  // Fold one sample in and return the rounded, saturated mean.
  function automatic logic signed [SMP_W-1:0] next_average(logic signed [SMP_W-1:0] s);
    int unsigned p;
    longint      total, mag, quo, n;
    p = slot_ptr;
    if (p >= avg_length) p = 0;
    window_total    = window_total - window_slots[p] + s;
    window_slots[p] = s;
    p++;
    if (p >= avg_length) p = 0;
    slot_ptr = p;
    if (seen_count < avg_length) seen_count++;
    n     = (seen_count == 0) ? 1 : seen_count;
    total = window_total;
    // round the magnitude, ties away from zero, then put the sign back
    mag = (total < 0) ? -total : total;
    quo = (mag + n / 2) / n;
    if (total < 0) quo = -quo;
    if (quo > 32767)  quo = 32767;
    if (quo < -32768) quo = -32768;
    return SMP_W'(quo);
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare every accepted average with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    logic signed [SMP_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (avg_due.size() == 0) begin
        flag_error($sformatf("average %0d with no request outstanding", out_average_out));
      end else begin
        want = avg_due.pop_front();
        if (out_average_out !== want)
          flag_error($sformatf("average_out expected %0d got %0d", want, out_average_out));
      end
    end
  end

  // Watchdog: too long without any request, result or register access moving.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("moving_average_filter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one sample; valid stays high afterwards unless the caller drops it.
  task automatic push_sample(input logic signed [SMP_W-1:0] s, input logic typed,
                             input logic signed [SMP_W-1:0] want);
    logic signed [SMP_W-1:0] pred;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    n_sent++;
    pred = next_average(s);
    avg_due.push_back(typed ? want : pred);
  endtask

  // Hold off the sender until every owed average has come back.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (avg_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register access; pready is waited for even though it is tied high.
  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the owed averages, write, update the predictor, then read the length back.
  task automatic write_length(input logic [PADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] rd;
    drain_requests();
    reg_access(1'b1, a, d, rd);
    note_length_write(a, d);
    n_len_writes++;
    reg_access(1'b0, ADDR_LENGTH, '0, rd);
    if (rd[LEN_W-1:0] !== LEN_W'(avg_length))
      flag_error($sformatf("window_length reads %0d, expected %0d", rd[LEN_W-1:0], avg_length));
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample(sample_mix_t mix);
    case (mix)
      MIX_UNIFORM: return SMP_W'($urandom);
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return Q15_MAX;
          1:       return Q15_MIN;
          2:       return '0;
          3:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      // tiny values: sums land on exact halves often, exercising tie rounding
      MIX_TIES:    return SMP_W'($urandom_range(0, 6)) - 16'sd3;
      default: begin
        if ($urandom_range(0, 1)) return Q15_MAX - SMP_W'($urandom_range(0, 255));
        return Q15_MIN + SMP_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan. Typed expectations only where obvious: first sample after
  // a clear, length-one windows, two-sample ties and full-scale runs.
  // ---------------------------------------------------------------------------
  plan_row_t plan [PLAN_ROWS];

  initial begin
    logic [DATA_W-1:0]  rd;
    logic [PADDR_W-1:0] where;
    logic [DATA_W-1:0]  word;
    sample_mix_t        mix;
    int unsigned        phase_items;
    int unsigned        first_random;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_on      = 1'b1;
    n_sent       = 0;
    n_results    = 0;
    n_len_writes = 0;
    n_errors     = 0;
    avg_length   = LEN_RESET;
    clear_window_state();

    plan = '{
      // reset length 8: first sample is its own mean
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, 16'sd100},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      // zero length acts as one
      '{ROW_WRITE,  ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, Q15_MAX},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, Q15_MIN},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, -16'sd1},
      // length two: half-way sums round away from zero on both sides
      '{ROW_WRITE,  ADDR_LENGTH,   32'd2,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, 16'sd1},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, 16'sd1},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, -16'sd1},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, -16'sd2},
      // write to an unmapped index: window must survive
      '{ROW_WRITE,  ADDR_UNMAPPED, 32'd5,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      // above the maximum: clamps to 1024
      '{ROW_WRITE,  ADDR_LENGTH,   32'd2047, 1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, Q15_MAX},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, Q15_MAX},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      // only the low 11 bits count: 0x800 is a zero length
      '{ROW_WRITE,  ADDR_LENGTH,   32'h800,  1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, -16'sd5},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b1, 16'sd12345},
      '{ROW_WRITE,  ADDR_LENGTH,   32'd3,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0},
      '{ROW_SAMPLE, ADDR_LENGTH,   32'd0,    1'b0, 16'sd0}
    };
    // nonzero sample values for the sample rows, typed or checked by the predictor
    plan[1].data  = 32'(Q15_MIN);
    plan[2].data  = 32'(Q15_MAX);
    plan[4].data  = 32'(Q15_MAX);
    plan[5].data  = 32'(Q15_MIN);
    plan[6].data  = 32'hFFFF;
    plan[8].data  = 32'd1;
    plan[10].data = 32'hFFFF;
    plan[11].data = 32'hFFFE;
    plan[13].data = 32'd3;
    plan[15].data = 32'(Q15_MAX);
    plan[16].data = 32'(Q15_MAX);
    plan[17].data = 32'(Q15_MIN);
    plan[19].data = 32'hFFFB;
    plan[20].data = 32'd12345;
    plan[22].data = 32'd1;
    plan[23].data = 32'd1;
    plan[25].data = 32'(Q15_MIN);
    plan[0].data  = 32'd100;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the length register
    reg_access(1'b0, ADDR_LENGTH, '0, rd);
    if (rd[LEN_W-1:0] !== LEN_RESET)
      flag_error($sformatf("window_length after reset reads %0d", rd[LEN_W-1:0]));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_length(plan[i].addr, plan[i].data);
      end else begin
        push_sample(SMP_W'(plan[i].data), plan[i].typed, plan[i].want);
      end
    end

    // Full-depth phase, no idling on either side: run the sum down to its
    // most negative value and past the wrap of the write pointer.
    first_random = n_sent;
    write_length(ADDR_LENGTH, 32'd1500);
    idle_on = 1'b0;
    repeat (BIG_RUN) push_sample(Q15_MIN, 1'b0, '0);
    idle_on = 1'b1;
    repeat (40) push_sample(pick_sample(MIX_UNIFORM), 1'b0, '0);

    // Random phases: mostly short windows so the pointer wraps many times.
    while (n_sent - first_random < RANDOM_ITEMS) begin
      where = ADDR_LENGTH;
      case ($urandom_range(0, 9))
        0:       word = $urandom;
        1: begin
          where = ADDR_UNMAPPED;
          word  = $urandom;
        end
        2:       word = 32'd0;
        3:       word = $urandom_range(0, 1) ? 32'd2047 : 32'd1024;
        default: word = $urandom_range(1, 24);
      endcase
      write_length(where, word);
      mix         = sample_mix_t'($urandom_range(0, 3));
      phase_items = $urandom_range(1, (avg_length < 20) ? 3 * avg_length + 3 : 60);
      repeat (phase_items) begin
        push_sample(pick_sample(mix), 1'b0, '0);
        // sender occasionally waits for every owed average
        if ($urandom_range(0, 99) < 2) drain_requests();
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (avg_due.size() != 0) begin
      flag_error($sformatf("average %0d never arrived", avg_due.pop_front()));
    end

    $display("covered %0d samples over %0d length writes (clamps, unmapped index, wrap at 1024)",
             n_sent, n_len_writes);
    $display("%0d averages checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("moving_average_filter regression: pass");
    end else begin
      $display("moving_average_filter regression: fail");
    end
    $finish;
  end

endmodule
